>>> sv/assert_macros.svh
// Assertion macros for the rotated sprite blitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock while out of reset.
`define RSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen while out of reset.
`define RSB_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/rsb_pkg.sv
// Constants and types shared by the rotated sprite blitter.
package rsb_pkg;

    localparam int SPRITE_MAX_W = 128;
    localparam int SPRITE_MAX_H = 128;
    localparam int DEST_SIDE    = 4096;
    localparam int FRAC_BITS    = 16;

    localparam int X_BITS = $clog2(SPRITE_MAX_W);
    localparam int Y_BITS = $clog2(SPRITE_MAX_H);
    localparam int ADDR_W = X_BITS + Y_BITS;
    localparam int DEPTH  = SPRITE_MAX_W * SPRITE_MAX_H;

    // field widths
    localparam int PIX_W   = 32;
    localparam int LOAD_W  = 7;
    localparam int DST_W   = 12;
    localparam int TRIG_W  = 18;
    localparam int SIZE_W  = 8;
    localparam int PSRC_W  = 9;
    localparam int PDST_W  = 14;

    // datapath widths
    localparam int RX_W   = PDST_W + 1;
    localparam int PROD_W = RX_W + TRIG_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int SRC_W  = ACC_W - FRAC_BITS + 1;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = TRIG_W;

    localparam logic [CFG_IDX_W-1:0] REG_SINE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COSINE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PSRC_X  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PSRC_Y  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PDST_X  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PDST_Y  = 4'd7;

    localparam logic signed [TRIG_W-1:0] COSINE_RESET = 18'sd65536;
    localparam logic [SIZE_W-1:0]        SIZE_RESET   = 8'd128;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sine_q16;
        logic signed [TRIG_W-1:0] cosine_q16;
        logic [SIZE_W-1:0]        sprite_width;
        logic [SIZE_W-1:0]        sprite_height;
        logic signed [PSRC_W-1:0] pivot_src_x;
        logic signed [PSRC_W-1:0] pivot_src_y;
        logic signed [PDST_W-1:0] pivot_dst_x;
        logic signed [PDST_W-1:0] pivot_dst_y;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [LOAD_W-1:0] load_col;
        logic [LOAD_W-1:0] load_row;
        logic [PIX_W-1:0]  pixel_value;
        logic [DST_W-1:0]  dst_col;
        logic [DST_W-1:0]  dst_row;
    } item_t;

    // memory access handed from the address pipeline to the store stage
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } access_t;

endpackage

>>> sv/rsb_req_if.sv
// Input channel of the rotated sprite blitter: load and draw words.
interface rsb_req_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [rsb_pkg::LOAD_W-1:0]     load_col;
    logic [rsb_pkg::LOAD_W-1:0]     load_row;
    logic [rsb_pkg::PIX_W-1:0]      pixel_value;
    logic [rsb_pkg::DST_W-1:0]      dst_col;
    logic [rsb_pkg::DST_W-1:0]      dst_row;

    modport source (
        output valid, kind, load_col, load_row, pixel_value, dst_col, dst_row,
        input  ready
    );
    modport sink (
        input  valid, kind, load_col, load_row, pixel_value, dst_col, dst_row,
        output ready
    );
endinterface

>>> sv/rsb_rsp_if.sv
// Output channel of the rotated sprite blitter: one word per draw.
interface rsb_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [rsb_pkg::PIX_W-1:0] out_pixel;
    logic                      drawn;

    modport source (
        output valid, out_pixel, drawn,
        input  ready
    );
    modport sink (
        input  valid, out_pixel, drawn,
        output ready
    );
endinterface

>>> sv/rotated_sprite_blit.sv
// Top level of the rotated sprite blitter: config, store stage and output.

// One word is taken per clock unless the output stalls, and each draw word gives one
// result word; a load word gives none. The rate is set by the single-port sprite
// memory, which serves one load write or one draw read per cycle at a fixed pipeline
// stage, so loads and draws reach the store in arrival order. Backpressure on the
// output freezes the whole pipeline, memory included, and ready drops in the same
// cycle. Sprite entries hold nothing defined until loaded; there is no clearing pass.
`include "assert_macros.svh"

module rotated_sprite_blit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rsb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    rsb_req_if.sink                         req,
    rsb_rsp_if.source                       rsp
);

    rsb_pkg::cfg_t    cfg_reg;
    rsb_pkg::item_t   item;
    rsb_pkg::access_t acc;

    logic adv, accept;

    // store stage
    logic                       ms_valid_reg, ms_draw_reg, ms_ok_reg;
    logic [rsb_pkg::PIX_W-1:0]  ms_pix_reg;
    logic [rsb_pkg::PIX_W-1:0]  rdata;
    logic                       mem_en, mem_we;

    // output word
    logic                       out_valid_reg, out_drawn_reg;
    logic [rsb_pkg::PIX_W-1:0]  out_pixel_reg;
    logic                       hit;

    assign adv    = !out_valid_reg || rsp.ready;
    assign accept = req.valid && adv;
    assign req.ready = adv;

    assign item.kind        = req.kind;
    assign item.load_col    = req.load_col;
    assign item.load_row    = req.load_row;
    assign item.pixel_value = req.pixel_value;
    assign item.dst_col     = req.dst_col;
    assign item.dst_row     = req.dst_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sine_q16      <= '0;
            cfg_reg.cosine_q16    <= rsb_pkg::COSINE_RESET;
            cfg_reg.sprite_width  <= rsb_pkg::SIZE_RESET;
            cfg_reg.sprite_height <= rsb_pkg::SIZE_RESET;
            cfg_reg.pivot_src_x   <= '0;
            cfg_reg.pivot_src_y   <= '0;
            cfg_reg.pivot_dst_x   <= '0;
            cfg_reg.pivot_dst_y   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsb_pkg::REG_SINE:   cfg_reg.sine_q16      <= $signed(cfg_data);
                rsb_pkg::REG_COSINE: cfg_reg.cosine_q16    <= $signed(cfg_data);
                rsb_pkg::REG_WIDTH:  cfg_reg.sprite_width  <= cfg_data[rsb_pkg::SIZE_W-1:0];
                rsb_pkg::REG_HEIGHT: cfg_reg.sprite_height <= cfg_data[rsb_pkg::SIZE_W-1:0];
                rsb_pkg::REG_PSRC_X: cfg_reg.pivot_src_x   <= $signed(cfg_data[rsb_pkg::PSRC_W-1:0]);
                rsb_pkg::REG_PSRC_Y: cfg_reg.pivot_src_y   <= $signed(cfg_data[rsb_pkg::PSRC_W-1:0]);
                rsb_pkg::REG_PDST_X: cfg_reg.pivot_dst_x   <= $signed(cfg_data[rsb_pkg::PDST_W-1:0]);
                rsb_pkg::REG_PDST_Y: cfg_reg.pivot_dst_y   <= $signed(cfg_data[rsb_pkg::PDST_W-1:0]);
                default: ;
            endcase
        end
    end

    rsb_map u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .acc    (acc)
    );

    // out-of-store loads and out-of-bounds draws leave the port idle
    assign mem_en = adv && acc.valid && acc.ok;
    assign mem_we = (acc.kind == rsb_pkg::KIND_LOAD);

    rsb_sram u_sram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (acc.addr),
        .wdata (acc.pix),
        .rdata (rdata)
    );

    assign hit = ms_ok_reg && (rdata != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ms_valid_reg  <= acc.valid;
            out_valid_reg <= ms_valid_reg && ms_draw_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ms_draw_reg   <= (acc.kind == rsb_pkg::KIND_DRAW);
            ms_ok_reg     <= acc.ok;
            ms_pix_reg    <= acc.pix;
            out_drawn_reg <= hit;
            out_pixel_reg <= hit ? rdata : ms_pix_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_pixel = out_pixel_reg;
    assign rsp.drawn     = out_drawn_reg;

    `RSB_ASSERT(a_drawn_nonzero, rsp.valid && rsp.drawn |-> rsp.out_pixel != '0, "drawn word carries a zero pixel")
    `RSB_ASSERT(a_load_no_word, adv && ms_valid_reg && !ms_draw_reg |=> !out_valid_reg, "load word produced a result")
    `RSB_ASSERT(a_oob_kept, adv && ms_valid_reg && ms_draw_reg && !ms_ok_reg |=> !out_drawn_reg && out_pixel_reg == $past(ms_pix_reg), "out-of-bounds draw replaced the pixel")
    `RSB_ASSERT_NEVER(a_mem_on_stall, mem_en && !adv, "sprite memory accessed during a stall")

endmodule

>>> sv/rsb_sram.sv
// Single-port sprite memory, synchronous read with registered data.
module rsb_sram (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       we,
    input  logic [rsb_pkg::ADDR_W-1:0] addr,
    input  logic [rsb_pkg::PIX_W-1:0]  wdata,
    output logic [rsb_pkg::PIX_W-1:0]  rdata
);

    logic [rsb_pkg::PIX_W-1:0] mem [rsb_pkg::DEPTH];
    logic [rsb_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
    end

    // read data holds while the port is idle
    always_ff @(posedge clk)
    begin
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/rsb_map.sv
// Address pipeline: maps a destination position back into the sprite.
module rsb_map (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             accept,
    input  rsb_pkg::item_t   item,
    input  rsb_pkg::cfg_t    cfg,
    output rsb_pkg::access_t acc
);

    localparam int SRC_W  = rsb_pkg::SRC_W;
    localparam int RX_W   = rsb_pkg::RX_W;
    localparam int PROD_W = rsb_pkg::PROD_W;
    localparam int ACC_W  = rsb_pkg::ACC_W;
    localparam int LOAD_W = rsb_pkg::LOAD_W;
    localparam int PIX_W  = rsb_pkg::PIX_W;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: offsets from the destination pivot
    logic                     kind1_reg, dok1_reg;
    logic signed [RX_W-1:0]   rx_reg, ry_reg;
    logic [LOAD_W-1:0]        lc1_reg, lr1_reg;
    logic [PIX_W-1:0]         pix1_reg;
    logic signed [RX_W-1:0]   rx_next, ry_next;
    logic                     dok_next;

    // stage 2: products
    logic                     kind2_reg, dok2_reg;
    logic signed [PROD_W-1:0] p_xc_reg, p_ys_reg, p_yc_reg, p_xs_reg;
    logic [LOAD_W-1:0]        lc2_reg, lr2_reg;
    logic [PIX_W-1:0]         pix2_reg;

    // stage 3: source coordinates
    logic                     kind3_reg, dok3_reg;
    logic signed [SRC_W-1:0]  sx_reg, sy_reg;
    logic [PIX_W-1:0]         pix3_reg;
    logic signed [ACC_W-1:0]  ax, ay;
    logic signed [SRC_W-1:0]  sx_next, sy_next;

    // stage 4: bounds and address
    logic                        kind4_reg, ok4_reg;
    logic [rsb_pkg::ADDR_W-1:0]  addr4_reg;
    logic [PIX_W-1:0]            pix4_reg;
    logic                        in_store, in_sprite, ok_next;

    always_comb
    begin
        rx_next  = $signed({3'b000, item.dst_col}) - RX_W'(cfg.pivot_dst_x);
        ry_next  = $signed({3'b000, item.dst_row}) - RX_W'(cfg.pivot_dst_y);
        dok_next = (32'(item.dst_col) < rsb_pkg::DEST_SIDE) &&
                   (32'(item.dst_row) < rsb_pkg::DEST_SIDE);
    end

    // floor by arithmetic shift of the 18.16 sums
    always_comb
    begin
        ax = ACC_W'(p_xc_reg) + ACC_W'(p_ys_reg);
        ay = ACC_W'(p_yc_reg) - ACC_W'(p_xs_reg);
        if (kind2_reg == rsb_pkg::KIND_DRAW)
        begin
            sx_next = SRC_W'($signed(ax[ACC_W-1:rsb_pkg::FRAC_BITS])) +
                      SRC_W'(cfg.pivot_src_x);
            sy_next = SRC_W'($signed(ay[ACC_W-1:rsb_pkg::FRAC_BITS])) +
                      SRC_W'(cfg.pivot_src_y);
        end
        else
        begin
            sx_next = $signed(SRC_W'(lc2_reg));
            sy_next = $signed(SRC_W'(lr2_reg));
        end
    end

    always_comb
    begin
        in_store  = (sx_reg >= 0) && (sy_reg >= 0) &&
                    (sx_reg < SRC_W'(rsb_pkg::SPRITE_MAX_W)) &&
                    (sy_reg < SRC_W'(rsb_pkg::SPRITE_MAX_H));
        in_sprite = (sx_reg < $signed(SRC_W'(cfg.sprite_width))) &&
                    (sy_reg < $signed(SRC_W'(cfg.sprite_height)));
        if (kind3_reg == rsb_pkg::KIND_DRAW)
        begin
            ok_next = in_store && in_sprite && dok3_reg;
        end
        else
        begin
            ok_next = in_store;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind1_reg <= item.kind;
            dok1_reg  <= dok_next;
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            lc1_reg   <= item.load_col;
            lr1_reg   <= item.load_row;
            pix1_reg  <= item.pixel_value;

            kind2_reg <= kind1_reg;
            dok2_reg  <= dok1_reg;
            p_xc_reg  <= PROD_W'(rx_reg) * PROD_W'(cfg.cosine_q16);
            p_ys_reg  <= PROD_W'(ry_reg) * PROD_W'(cfg.sine_q16);
            p_yc_reg  <= PROD_W'(ry_reg) * PROD_W'(cfg.cosine_q16);
            p_xs_reg  <= PROD_W'(rx_reg) * PROD_W'(cfg.sine_q16);
            lc2_reg   <= lc1_reg;
            lr2_reg   <= lr1_reg;
            pix2_reg  <= pix1_reg;

            kind3_reg <= kind2_reg;
            dok3_reg  <= dok2_reg;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            pix3_reg  <= pix2_reg;

            kind4_reg <= kind3_reg;
            ok4_reg   <= ok_next;
            addr4_reg <= {sy_reg[rsb_pkg::Y_BITS-1:0], sx_reg[rsb_pkg::X_BITS-1:0]};
            pix4_reg  <= pix3_reg;
        end
    end

    assign acc.valid = v4_reg;
    assign acc.kind  = kind4_reg;
    assign acc.ok    = ok4_reg;
    assign acc.addr  = addr4_reg;
    assign acc.pix   = pix4_reg;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the rotated sprite blitter: loads, draws and register phases.
module tb_top;
    import rsb_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES        = 13;
    localparam int PHASE_ITEMS   = 56;
    localparam int REPORT_MAX    = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd11;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    class blit_scoreboard;
        typedef struct {
            logic [PIX_W-1:0] pixel;
            logic             drawn;
        } blit_word_t;

        cfg_t             regs;
        logic [PIX_W-1:0] sprite_mem [DEPTH];
        bit               loaded [DEPTH];
        blit_word_t       expected_words [$];
        int               fail_count;

        function new();
            regs = '0;
            regs.cosine_q16 = COSINE_RESET;
            regs.sprite_width = SIZE_RESET;
            regs.sprite_height = SIZE_RESET;
            fail_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SINE:   regs.sine_q16 = data[TRIG_W-1:0];
                REG_COSINE: regs.cosine_q16 = data[TRIG_W-1:0];
                REG_WIDTH:  regs.sprite_width = data[SIZE_W-1:0];
                REG_HEIGHT: regs.sprite_height = data[SIZE_W-1:0];
                REG_PSRC_X: regs.pivot_src_x = data[PSRC_W-1:0];
                REG_PSRC_Y: regs.pivot_src_y = data[PSRC_W-1:0];
                REG_PDST_X: regs.pivot_dst_x = data[PDST_W-1:0];
                REG_PDST_Y: regs.pivot_dst_y = data[PDST_W-1:0];
                default: ;
            endcase
        endfunction

        // Rotate the destination position back into the sprite; 1 if it lands inside.
        function bit source_hit(logic [DST_W-1:0] dcol, logic [DST_W-1:0] drow,
                                output int addr);
            longint rx;
            longint ry;
            longint c;
            longint s;
            longint sx;
            longint sy;
            c = longint'($signed(regs.cosine_q16));
            s = longint'($signed(regs.sine_q16));
            rx = longint'(dcol) - longint'($signed(regs.pivot_dst_x));
            ry = longint'(drow) - longint'($signed(regs.pivot_dst_y));
            // >>> on a signed 64-bit value floors, same as the hardware shift
            sx = longint'($signed(regs.pivot_src_x)) + ((rx * c + ry * s) >>> FRAC_BITS);
            sy = longint'($signed(regs.pivot_src_y)) + ((ry * c - rx * s) >>> FRAC_BITS);
            addr = 0;
            if (sx < 0 || sy < 0 || sx >= SPRITE_MAX_W || sy >= SPRITE_MAX_H)
                return 1'b0;
            if (sx >= longint'(regs.sprite_width) || sy >= longint'(regs.sprite_height))
                return 1'b0;
            addr = int'(sy) * SPRITE_MAX_W + int'(sx);
            return 1'b1;
        endfunction

        function void note_item(item_t it);
            int         addr;
            bit         hit;
            blit_word_t w;
            if (it.kind == KIND_LOAD)
            begin
                if (it.load_col < SPRITE_MAX_W && it.load_row < SPRITE_MAX_H)
                begin
                    addr = int'(it.load_row) * SPRITE_MAX_W + int'(it.load_col);
                    sprite_mem[addr] = it.pixel_value;
                    loaded[addr] = 1'b1;
                end
                return;
            end
            w.pixel = it.pixel_value;
            w.drawn = 1'b0;
            if (it.dst_col < DEST_SIDE && it.dst_row < DEST_SIDE)
            begin
                hit = source_hit(it.dst_col, it.dst_row, addr);
                if (hit && sprite_mem[addr] != '0)
                begin
                    w.pixel = sprite_mem[addr];
                    w.drawn = 1'b1;
                end
            end
            expected_words.push_back(w);
        endfunction

        function void check_result(logic [PIX_W-1:0] pixel, logic drawn);
            blit_word_t w;
            if (expected_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result word: pixel %08h drawn %0b", pixel, drawn);
                return;
            end
            w = expected_words.pop_front();
            if (pixel !== w.pixel || drawn !== w.drawn)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("mismatch at %0t: expected pixel %08h drawn %0b, got pixel %08h drawn %0b",
                             $realtime, w.pixel, w.drawn, pixel, drawn);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rsb_req_if req_ch();
    rsb_rsp_if rsp_ch();

    rotated_sprite_blit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    blit_scoreboard blit_sb = new();
    int             burst_left = 0;
    bit             hold_request = 1'b0;
    int             idle_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [DST_W-1:0] to_dst(longint v);
        if (v < 0)
            return '0;
        if (v >= DEST_SIDE)
            return DST_W'(DEST_SIDE - 1);
        return DST_W'(v);
    endfunction

    // Sender works in bursts; valid stays high across words of one burst.
    task automatic send_item(item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= it.kind;
        req_ch.load_col    <= it.load_col;
        req_ch.load_row    <= it.load_row;
        req_ch.pixel_value <= it.pixel_value;
        req_ch.dst_col     <= it.dst_col;
        req_ch.dst_row     <= it.dst_row;
        do
            @(posedge clk);
        while (!req_ch.ready);
        blit_sb.note_item(it);
        burst_left--;
    endtask

    task automatic send_load(input logic [LOAD_W-1:0] col, input logic [LOAD_W-1:0] row,
                             input logic [PIX_W-1:0] pix);
        item_t it;
        it.kind        = KIND_LOAD;
        it.load_col    = col;
        it.load_row    = row;
        it.pixel_value = pix;
        it.dst_col     = DST_W'($urandom());
        it.dst_row     = DST_W'($urandom());
        send_item(it);
    endtask

    // A draw that would read a never-loaded sprite entry gets that entry loaded first.
    task automatic send_draw(input logic [DST_W-1:0] col, input logic [DST_W-1:0] row,
                             input logic [PIX_W-1:0] pix);
        item_t            it;
        int               addr;
        bit               hit;
        logic [PIX_W-1:0] fill;
        hit = blit_sb.source_hit(col, row, addr);
        if (hit && !blit_sb.loaded[addr])
        begin
            fill = ($urandom_range(0, 7) == 0) ? '0 : $urandom();
            send_load(LOAD_W'(addr % SPRITE_MAX_W), LOAD_W'(addr / SPRITE_MAX_W), fill);
        end
        it.kind        = KIND_DRAW;
        it.load_col    = LOAD_W'($urandom());
        it.load_row    = LOAD_W'($urandom());
        it.pixel_value = pix;
        it.dst_col     = col;
        it.dst_row     = row;
        send_item(it);
    endtask

    // Pick a source point in or around the sprite and rotate it forward to a destination.
    task automatic aimed_draw(int ew, int eh);
        longint tx;
        longint ty;
        longint u;
        longint v;
        longint c;
        longint s;
        longint rx;
        longint ry;
        tx = longint'($urandom_range(0, ew + 3)) - 2;
        ty = longint'($urandom_range(0, eh + 3)) - 2;
        c = longint'($signed(blit_sb.regs.cosine_q16));
        s = longint'($signed(blit_sb.regs.sine_q16));
        u = tx - longint'($signed(blit_sb.regs.pivot_src_x));
        v = ty - longint'($signed(blit_sb.regs.pivot_src_y));
        rx = (u * c - v * s) >>> FRAC_BITS;
        ry = (u * s + v * c) >>> FRAC_BITS;
        rx = rx + longint'($signed(blit_sb.regs.pivot_dst_x)) + longint'($urandom_range(0, 2)) - 1;
        ry = ry + longint'($signed(blit_sb.regs.pivot_dst_y)) + longint'($urandom_range(0, 2)) - 1;
        send_draw(to_dst(rx), to_dst(ry), rand_pixel());
    endtask

    task automatic random_item();
        int pick;
        int ew;
        int eh;
        ew = (blit_sb.regs.sprite_width == 0) ? 4 : int'(blit_sb.regs.sprite_width);
        eh = (blit_sb.regs.sprite_height == 0) ? 4 : int'(blit_sb.regs.sprite_height);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            aimed_draw(ew, eh);
        else if (pick < 70)
            send_load(LOAD_W'($urandom()), LOAD_W'($urandom()), rand_pixel());
        else if (pick < 82)
            send_load(LOAD_W'($urandom_range(0, (ew > SPRITE_MAX_W ? SPRITE_MAX_W : ew) - 1)),
                      LOAD_W'($urandom_range(0, (eh > SPRITE_MAX_H ? SPRITE_MAX_H : eh) - 1)),
                      rand_pixel());
        else
            send_draw(DST_W'($urandom()), DST_W'($urandom()), rand_pixel());
    endtask

    // Drop valid, wait for every outstanding result, then let trailing loads retire.
    task automatic drain_all();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (blit_sb.expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input int vals [8], input bit stray);
        logic [CFG_IDX_W-1:0]  ids [8];
        logic [CFG_DATA_W-1:0] junk;
        ids = '{REG_SINE, REG_COSINE, REG_WIDTH, REG_HEIGHT,
                REG_PSRC_X, REG_PSRC_Y, REG_PDST_X, REG_PDST_Y};
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= ids[i];
            cfg_data  <= CFG_DATA_W'(vals[i]);
            @(posedge clk);
            blit_sb.write_reg(ids[i], CFG_DATA_W'(vals[i]));
        end
        if (stray)
        begin
            junk = CFG_DATA_W'($urandom());
            cfg_index <= REG_UNUSED;
            cfg_data  <= junk;
            @(posedge clk);
            blit_sb.write_reg(REG_UNUSED, junk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic choose_settings(input int phase, output int vals [8]);
        int cos_tab [8];
        int sin_tab [8];
        int k;
        int w;
        int h;
        cos_tab = '{65536, 0, 46341, 56756, -32768, -46341, 60547, -65536};
        sin_tab = '{0, 65536, 46341, 32768, 56756, -46341, -25080, 0};
        case (phase)
            1: vals = '{65536, 0, 16, 16, 8, 8, 2000, 2000};
            2: vals = '{-65536, 0, 8, 24, 4, 12, 100, 3000};
            3: vals = '{0, -65536, 128, 128, 64, 64, 4000, 50};
            4: vals = '{-65536, -65536, 1, 1, -256, -256, -4096, -4096};
            5: vals = '{65536, 65536, 128, 128, 255, 255, 8191, 8191};
            6: vals = '{46341, 46341, 32, 20, 16, 10, 2048, 2048};
            // zero width: nothing can be in bounds
            7: vals = '{0, 65536, 0, 64, 0, 0, 10, 10};
            // size beyond the store: only the store limits apply
            8: vals = '{0, 65536, 200, 255, 0, 0, 0, 0};
            default:
            begin
                k = $urandom_range(0, 7);
                if ($urandom_range(0, 1))
                begin
                    vals[0] = sin_tab[k];
                    vals[1] = cos_tab[k];
                end
                else
                begin
                    vals[0] = int'($urandom_range(0, 131072)) - 65536;
                    vals[1] = int'($urandom_range(0, 131072)) - 65536;
                end
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 24);
                h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 24);
                vals[2] = w;
                vals[3] = h;
                vals[4] = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 511)) - 256
                                                      : $urandom_range(0, w);
                vals[5] = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 511)) - 256
                                                      : $urandom_range(0, h);
                vals[6] = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 12287)) - 4096
                                                      : $urandom_range(0, 4095);
                vals[7] = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 12287)) - 4096
                                                      : $urandom_range(0, 4095);
            end
        endcase
    endtask

    // Receiver: stall pattern changes per segment; a hold request forces a long stall.
    initial
    begin
        int          seg_left;
        int          hold_left;
        int          tick;
        stall_mode_t mode;
        logic        rdy;
        seg_left = 0;
        hold_left = 0;
        tick = 0;
        mode = STALL_NONE;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 150);
                mode = stall_mode_t'($urandom_range(0, 4));
            end
            seg_left--;
            case (mode)
                STALL_NONE:     rdy = 1'b1;
                STALL_HALF:     rdy = $urandom_range(0, 1);
                STALL_LIGHT:    rdy = ($urandom_range(0, 4) != 0);
                STALL_PERIODIC: rdy = (tick % 4 != 3);
                default:        rdy = ($urandom_range(0, 4) == 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            rsp_ch.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            blit_sb.check_result(rsp_ch.out_pixel, rsp_ch.drawn);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int vals [8];
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_LOAD;
        req_ch.load_col    <= '0;
        req_ch.load_row    <= '0;
        req_ch.pixel_value <= '0;
        req_ch.dst_col     <= '0;
        req_ch.dst_row     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers give an identity mapping: destination (c, r) reads sprite (c, r)
        send_load(7'd0, 7'd0, 32'hFFFF_FFFF);
        send_load(7'd127, 7'd127, 32'h0000_0001);
        send_load(7'd127, 7'd0, 32'hA5A5_A5A5);
        send_load(7'd0, 7'd127, 32'h5A5A_5A5A);
        send_load(7'd1, 7'd0, 32'h0);
        send_draw(12'd0, 12'd0, 32'h0);
        send_draw(12'd127, 12'd127, 32'hFFFF_FFFF);
        send_draw(12'd127, 12'd0, 32'h0);
        send_draw(12'd0, 12'd127, 32'h1);
        // zero sprite pixel keeps the destination
        send_draw(12'd1, 12'd0, 32'h1234_5678);
        send_draw(12'd128, 12'd0, 32'h0BAD_F00D);
        send_draw(12'd0, 12'd128, 32'hFFFF_FFFF);
        send_draw(12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send_draw(12'd4095, 12'd0, 32'h0);
        send_draw(12'd0, 12'd4095, 32'h8000_0000);
        send_load(7'd0, 7'd0, 32'h0);
        send_draw(12'd0, 12'd0, 32'h7FFF_FFFF);
        send_load(7'd0, 7'd0, 32'h8000_0000);
        send_draw(12'd0, 12'd0, 32'h0);
        send_draw(12'd0, 12'd0, 32'hFFFF_FFFF);

        for (int phase = 1; phase <= PHASES; phase++)
        begin
            drain_all();
            choose_settings(phase, vals);
            program_regs(vals, phase == 6);
            // long output stall while the sender keeps pushing
            if (phase == 3)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 9 && n == PHASE_ITEMS / 2)
                    drain_all();
                random_item();
            end
        end
        drain_all();

        if (blit_sb.expected_words.size() != 0)
        begin
            blit_sb.fail_count++;
            $display("%0d expected results never came out", blit_sb.expected_words.size());
        end
        if (blit_sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> rotated_sprite_blit.f
+incdir+sv
sv/rsb_pkg.sv
sv/rsb_req_if.sv
sv/rsb_rsp_if.sv
sv/rsb_sram.sv
sv/rsb_map.sv
sv/rotated_sprite_blit.sv
sim/tb_top.sv
